// ----- rtl/ftvs_pkg.sv -----
// Package for the flash tag/value store: geometry defaults, erased patterns,
// command and status codes. No dependencies.
package ftvs_pkg;

  localparam int unsigned PageWordsDef = 256;
  localparam int unsigned PageCountDef = 2;

  localparam logic [15:0] ERASED_HALF = 16'hffff;
  localparam logic [31:0] ERASED_WORD = 32'hffff_ffff;

  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_PAGE   = 2'd2;

endpackage

// ----- rtl/flash_tag_value_store.sv -----
// Top level of the flash tag/value store: sequencer around one page memory.
// Depends on ftvs_pkg.
//
// Usage: a request (cmd_i, tag_i, value_i) is taken when in_valid_i and
// in_ready_o are both high; exactly one result (status_o, read_value_o) per
// request comes out on the out_valid_o/out_ready_i channel. current_mark is
// written through cfg_valid_i/cfg_ready_o; the user must write it only while
// the block is idle, as the block itself does not enforce this. Requests are
// handled one at a time by a sequencer that reads, modifies and writes one
// word of the single-port store per step; every read has an issue step and
// a check step. A read scans the page headers, then the slots of the current
// page. A write scans up to PAGE_WORDS-1 slots; when it fills the page, the
// rescue copy moves the entries with a duplicate search in the target page,
// then erases the source. Initialize erases all pages but the current one
// (or all pages, then marks page 0, if none is current) at one word a cycle.
// After reset a clearing pass writes the erased pattern into all
// PAGE_COUNT*PAGE_WORDS words, one per cycle, before the first request is
// taken. A stalled result is held in the output register; the next request is
// still accepted and waits in its final step until the output is free.
module flash_tag_value_store
  import ftvs_pkg::*;
#(
  parameter int unsigned PAGE_WORDS = PageWordsDef,
  parameter int unsigned PAGE_COUNT = PageCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_current_mark_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] tag_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] read_value_o
);

  localparam int unsigned Depth = PAGE_COUNT * PAGE_WORDS;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned SW = $clog2(PAGE_WORDS);
  localparam int unsigned FW = $clog2(PAGE_WORDS + 1);
  localparam int unsigned PB = $clog2(PAGE_COUNT);
  localparam logic [SW-1:0] LastSlot = SW'(PAGE_WORDS - 1);
  localparam logic [PB-1:0] LastPage = PB'(PAGE_COUNT - 1);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_LOC_RD  = 5'd2;
  localparam logic [4:0] S_LOC_CHK = 5'd3;
  localparam logic [4:0] S_ERASE   = 5'd4;
  localparam logic [4:0] S_MARK0   = 5'd5;
  localparam logic [4:0] S_RD_RD   = 5'd6;
  localparam logic [4:0] S_RD_CHK  = 5'd7;
  localparam logic [4:0] S_WR_RD   = 5'd8;
  localparam logic [4:0] S_WR_CHK  = 5'd9;
  localparam logic [4:0] S_MF_RD   = 5'd10;
  localparam logic [4:0] S_MF_CHK  = 5'd11;
  localparam logic [4:0] S_MV_RD   = 5'd12;
  localparam logic [4:0] S_MV_W    = 5'd13;
  localparam logic [4:0] S_MV_SRD  = 5'd14;
  localparam logic [4:0] S_MV_SCHK = 5'd15;
  localparam logic [4:0] S_HDR_RD  = 5'd16;
  localparam logic [4:0] S_HDR_W   = 5'd17;
  localparam logic [4:0] S_ESRC    = 5'd18;
  localparam logic [4:0] S_DONE    = 5'd19;

  logic [4:0]    state_q, state_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [15:0]   tag_q, tag_d;
  logic [15:0]   val_q, val_d;
  logic [15:0]   mark_q;
  logic [PB-1:0] page_q, page_d;
  logic [PB-1:0] cur_q, cur_d;
  logic [PB-1:0] dst_q, dst_d;
  logic          found_q, found_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] k_q, k_d;
  logic [31:0]   w_q, w_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [15:0]   res_rv_q, res_rv_d;
  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [15:0]   rv_q;

  logic [31:0]   mem [Depth];
  logic [31:0]   rdata_q;
  logic          mem_re, mem_we;
  logic [PB-1:0] mem_page;
  logic [SW-1:0] mem_slot;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic          out_load;
  logic          erase_skip;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = rv_q;
  assign erase_skip   = found_q && (page_q == cur_q);
  assign out_load     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (state_q == S_CLR) begin
      mem_addr = clr_q;
    end else begin
      mem_addr = AW'(AW'(mem_page) * AW'(PAGE_WORDS)) + AW'(mem_slot);
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    tag_d        = tag_q;
    val_d        = val_q;
    page_d       = page_q;
    cur_d        = cur_q;
    dst_d        = dst_q;
    found_d      = found_q;
    slot_d       = slot_q;
    fill_d       = fill_q;
    k_d          = k_q;
    w_d          = w_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_rv_d     = res_rv_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_page     = cur_q;
    mem_slot     = slot_q;
    mem_wdata    = ERASED_WORD;

    case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_i;
          tag_d        = tag_i;
          val_d        = value_i;
          page_d       = '0;
          res_status_d = ST_OK;
          res_rv_d     = '0;
          if (cmd_i == CMD_INIT || cmd_i == CMD_READ || cmd_i == CMD_WRITE) begin
            state_d = S_LOC_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_LOC_RD: begin
        mem_re   = 1'b1;
        mem_page = page_q;
        mem_slot = '0;
        state_d  = S_LOC_CHK;
      end
      S_LOC_CHK: begin
        if (rdata_q[15:0] == mark_q || page_q == LastPage) begin
          found_d = (rdata_q[15:0] == mark_q);
          cur_d   = page_q;
          case (cmd_q)
            CMD_INIT: begin
              page_d  = '0;
              slot_d  = '0;
              state_d = S_ERASE;
            end
            CMD_READ: begin
              slot_d = LastSlot;
              if (rdata_q[15:0] == mark_q) begin
                state_d = S_RD_RD;
              end else begin
                res_status_d = ST_NO_PAGE;
                state_d      = S_DONE;
              end
            end
            default: begin
              slot_d = SW'(1);
              if (rdata_q[15:0] == mark_q) begin
                state_d = S_WR_RD;
              end else begin
                res_status_d = ST_NO_PAGE;
                state_d      = S_DONE;
              end
            end
          endcase
        end else begin
          page_d  = page_q + 1'b1;
          state_d = S_LOC_RD;
        end
      end
      S_ERASE: begin
        mem_page = page_q;
        mem_we   = !erase_skip;
        if (erase_skip || slot_q == LastSlot) begin
          slot_d = '0;
          if (page_q == LastPage) begin
            state_d = found_q ? S_MF_RD : S_MARK0;
          end else begin
            page_d = page_q + 1'b1;
          end
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      S_MARK0: begin
        // Page 0 has just been erased, so its header's high half is erased.
        mem_we    = 1'b1;
        mem_page  = '0;
        mem_slot  = '0;
        mem_wdata = {ERASED_HALF, mark_q};
        state_d   = S_DONE;
      end
      S_RD_RD: begin
        mem_re  = 1'b1;
        state_d = S_RD_CHK;
      end
      S_RD_CHK: begin
        if (rdata_q[15:0] == tag_q) begin
          res_rv_d = rdata_q[31:16];
          state_d  = S_DONE;
        end else if (slot_q == SW'(1)) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          slot_d  = slot_q - 1'b1;
          state_d = S_RD_RD;
        end
      end
      S_WR_RD: begin
        mem_re  = 1'b1;
        state_d = S_WR_CHK;
      end
      S_WR_CHK: begin
        if (rdata_q[15:0] == ERASED_HALF) begin
          mem_we    = 1'b1;
          mem_wdata = {val_q, tag_q};
          state_d   = S_MF_RD;
        end else if (slot_q == LastSlot) begin
          state_d = S_MF_RD;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_WR_RD;
        end
      end
      S_MF_RD: begin
        mem_re   = 1'b1;
        mem_slot = LastSlot;
        state_d  = S_MF_CHK;
      end
      S_MF_CHK: begin
        if (rdata_q == ERASED_WORD) begin
          state_d = S_DONE;
        end else begin
          dst_d   = (cur_q == LastPage) ? '0 : cur_q + 1'b1;
          fill_d  = FW'(1);
          slot_d  = LastSlot;
          state_d = S_MV_RD;
        end
      end
      S_MV_RD: begin
        mem_re  = 1'b1;
        state_d = S_MV_W;
      end
      S_MV_W: begin
        w_d = rdata_q;
        k_d = FW'(1);
        if (rdata_q[15:0] != ERASED_HALF) begin
          state_d = S_MV_SRD;
        end else if (slot_q == SW'(1)) begin
          state_d = S_HDR_RD;
        end else begin
          slot_d  = slot_q - 1'b1;
          state_d = S_MV_RD;
        end
      end
      S_MV_SRD: begin
        mem_page = dst_q;
        mem_slot = k_q[SW-1:0];
        if (k_q == fill_q) begin
          // The tag is not yet in the target page: append it if there is room.
          if (fill_q != FW'(PAGE_WORDS)) begin
            mem_we    = 1'b1;
            mem_slot  = fill_q[SW-1:0];
            mem_wdata = w_q;
            fill_d    = fill_q + 1'b1;
          end
          if (slot_q == SW'(1)) begin
            state_d = S_HDR_RD;
          end else begin
            slot_d  = slot_q - 1'b1;
            state_d = S_MV_RD;
          end
        end else begin
          mem_re  = 1'b1;
          state_d = S_MV_SCHK;
        end
      end
      S_MV_SCHK: begin
        if (rdata_q[15:0] == w_q[15:0]) begin
          if (slot_q == SW'(1)) begin
            state_d = S_HDR_RD;
          end else begin
            slot_d  = slot_q - 1'b1;
            state_d = S_MV_RD;
          end
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_MV_SRD;
        end
      end
      S_HDR_RD: begin
        mem_re   = 1'b1;
        mem_page = dst_q;
        mem_slot = '0;
        state_d  = S_HDR_W;
      end
      S_HDR_W: begin
        mem_we    = 1'b1;
        mem_page  = dst_q;
        mem_slot  = '0;
        mem_wdata = {rdata_q[31:16], mark_q};
        slot_d    = '0;
        state_d   = S_ESRC;
      end
      S_ESRC: begin
        mem_we = 1'b1;
        slot_d = slot_q + 1'b1;
        if (slot_q == LastSlot) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Every read is consumed in the step after it is issued, and no step reads
  // and writes at once, so a read never overlaps a pending write.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      fill_q      <= '0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      found_q <= found_d;
      fill_q  <= fill_d;
      k_q     <= k_d;
      if (cfg_valid_i) begin
        mark_q <= cfg_current_mark_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    tag_q        <= tag_d;
    val_q        <= val_d;
    page_q       <= page_d;
    cur_q        <= cur_d;
    dst_q        <= dst_d;
    slot_q       <= slot_d;
    w_q          <= w_d;
    res_status_q <= res_status_d;
    res_rv_q     <= res_rv_d;
    if (out_load) begin
      status_q <= res_status_q;
      rv_q     <= res_rv_q;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block took a second request without finishing the first");

  a_unused_cmd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_UNUSED |=> state_q == S_DONE)
    else $error("unused command did not finish at once");

  a_copy_not_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MV_SRD || state_q == S_HDR_W) && mem_we |-> dst_q != cur_q)
    else $error("rescue copy targets its own source page");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(PAGE_WORDS))
    else $error("rescue fill count beyond page size");

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !mem_re)
    else $error("memory read and write in the same step");
`endif

endmodule
